>>> rtl/linear_probe_hash_set_top_macros.svh
// ----------------------------------------------------------------------------
// Hash set assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_SET_TOP_MACROS_SVH
`define LINEAR_PROBE_HASH_SET_TOP_MACROS_SVH

// same-cycle implication
`define LPHS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hash set assertion failed");

// next-cycle implication
`define LPHS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hash set assertion failed");

`endif

>>> rtl/lphs_pkg.sv
// ----------------------------------------------------------------------------
// Hash set package
// Field widths, request and status codes, register indexes and beat types.
// ----------------------------------------------------------------------------
`default_nettype none

package lphs_pkg;

  localparam int unsigned KEY_IN_W  = 32;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned LIMIT_W   = 7;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned KEY_WIDTH_DEF   = 32;
  localparam int unsigned MAX_PROBE_LIMIT = 64;

  localparam int unsigned SIZE_MAX  = (2 ** SIZE_W) - 1;
  localparam int unsigned LIMIT_MAX = (2 ** LIMIT_W) - 1;
  localparam int unsigned LIMIT_CAP =
    (MAX_PROBE_LIMIT > LIMIT_MAX) ? LIMIT_MAX : MAX_PROBE_LIMIT;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(1021);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NEED_GROW = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 3'd6;

  localparam logic CFG_TABLE_SIZE  = 1'b0;
  localparam logic CFG_PROBE_LIMIT = 1'b1;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [KEY_IN_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/lphs_mem.sv
// ----------------------------------------------------------------------------
// Hash set slot memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_mem #(
  parameter int unsigned DEPTH = lphs_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned WIDTH = lphs_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/lphs_mod.sv
// ----------------------------------------------------------------------------
// Hash set modulo unit
// Restoring bit-serial remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_mod #(
  parameter int unsigned KEY_WIDTH = lphs_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start_i,
  input  wire logic [KEY_WIDTH-1:0]        dividend_i,
  input  wire logic [lphs_pkg::SIZE_W-1:0] divisor_i,
  output logic                             done_o,
  output logic      [lphs_pkg::SIZE_W-1:0] rem_o
);

  import lphs_pkg::*;

  localparam int unsigned CNT_W = $clog2(KEY_WIDTH);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [KEY_WIDTH-1:0] sh_r;
  logic [SIZE_W-1:0]    div_r;
  logic [SIZE_W-1:0]    rem_r;
  logic [SIZE_W:0]      trial;
  logic [SIZE_W:0]      diff;
  logic [SIZE_W-1:0]    rem_nxt;

  always_comb begin
    trial = {rem_r, sh_r[KEY_WIDTH-1]};
    diff  = trial - {1'b0, div_r};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = diff[SIZE_W-1:0];
    end else begin
      rem_nxt = trial[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(KEY_WIDTH - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      sh_r  <= dividend_i;
      div_r <= divisor_i;
      rem_r <= '0;
    end else if (busy_r) begin
      sh_r  <= {sh_r[KEY_WIDTH-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done_o = done_r;
  assign rem_o  = rem_r;

endmodule

`default_nettype wire

>>> rtl/linear_probe_hash_set_top.sv
// Lookup and insert: the bit-serial modulo unit computes the home slot, then the probe
// reads one slot per cycle from the slot memory, 1 to probe_limit slots in all.
// Zero key or zero probe limit: result in the cycle after accept. Clear: zeroes every slot.
// A new request is taken in the cycle its predecessor's result is shown.
// Reset runs a clearing pass over every slot with busy high; results are never stalled.
// ----------------------------------------------------------------------------
// Linear probing hash set
// Nonzero keys in an open addressed table, home slot key mod table_size.
// ----------------------------------------------------------------------------
`default_nettype none

`include "linear_probe_hash_set_top_macros.svh"

module linear_probe_hash_set_top #(
  parameter int unsigned TABLE_DEPTH = lphs_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_WIDTH   = lphs_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire lphs_pkg::req_t               in_req,
  output logic                              out_valid,
  output lphs_pkg::res_t                    out_res,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_idx,
  input  wire logic [lphs_pkg::SIZE_W-1:0]  cfg_wdata
);

  import lphs_pkg::*;

  localparam int unsigned IDX_W     = $clog2(TABLE_DEPTH);
  localparam int unsigned DEPTH_CAP = (TABLE_DEPTH > SIZE_MAX) ? SIZE_MAX : TABLE_DEPTH;
  localparam logic [SIZE_W-1:0]  DEPTH_CAP_V = SIZE_W'(DEPTH_CAP);
  localparam logic [LIMIT_W-1:0] LIMIT_CAP_V = LIMIT_W'(LIMIT_CAP);
  localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_HASH  = 4'b0100,
    S_CHECK = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     clr_r, clr_nxt;
  logic                 clr_rep_r, clr_rep_nxt;
  logic [SIZE_W-1:0]    k_r, k_nxt;
  logic [LIMIT_W-1:0]   cnt_r, cnt_nxt;
  logic                 ins_r, ins_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_r, out_nxt;
  logic [SIZE_W-1:0]    size_cfg_r;
  logic [LIMIT_W-1:0]   limit_cfg_r;

  logic [SIZE_W-1:0]          sz;
  logic [LIMIT_W-1:0]         lim;
  logic [KEY_WIDTH+KEY_IN_W-1:0] key_ext;
  logic [KEY_WIDTH-1:0]       key_w;
  logic [SIZE_W-1:0]          k_inc;
  logic [SIZE_W-1:0]          k_rd;
  logic [SIZE_W+IDX_W-1:0]    k_rd_ext;
  logic [SIZE_W+IDX_W-1:0]    k_wr_ext;
  logic                       accept;
  logic                       mod_start;
  logic                       mod_done;
  logic [SIZE_W-1:0]          mod_rem;
  logic                       mem_we;
  logic [IDX_W-1:0]           mem_waddr;
  logic [KEY_WIDTH-1:0]       mem_wdata;
  logic [KEY_WIDTH-1:0]       mem_rdata;

  always_comb begin
    if (size_cfg_r == '0) begin
      sz = SIZE_W'(1);
    end else if (size_cfg_r > DEPTH_CAP_V) begin
      sz = DEPTH_CAP_V;
    end else begin
      sz = size_cfg_r;
    end
    lim = (limit_cfg_r > LIMIT_CAP_V) ? LIMIT_CAP_V : limit_cfg_r;
  end

  assign key_ext  = {{KEY_WIDTH{1'b0}}, in_req.key};
  assign key_w    = key_ext[KEY_WIDTH-1:0];
  assign accept   = start && (state_r == S_IDLE);
  assign k_inc    = ((SIZE_W'(k_r + 1'b1)) >= sz) ? '0 : SIZE_W'(k_r + 1'b1);
  assign k_rd     = (state_r == S_HASH) ? mod_rem : k_inc;
  assign k_rd_ext = {{IDX_W{1'b0}}, k_rd};
  assign k_wr_ext = {{IDX_W{1'b0}}, k_r};

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    clr_rep_nxt   = clr_rep_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    ins_nxt       = ins_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mod_start     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = k_wr_ext[IDX_W-1:0];
    mem_wdata     = key_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = clr_rep_r;
          out_nxt       = '{status: ST_CLEARED, slot: '0};
        end
      end
      S_IDLE: begin
        if (accept) begin
          ins_nxt = (in_req.req_type == REQ_INSERT);
          key_nxt = key_w;
          if (in_req.req_type == REQ_CLEAR) begin
            state_nxt   = S_CLEAR;
            clr_nxt     = '0;
            clr_rep_nxt = 1'b1;
          end else if (key_w == '0) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: ST_ZERO_KEY, slot: '0};
          end else if (lim == '0) begin
            out_valid_nxt = 1'b1;
            out_nxt.status = (in_req.req_type == REQ_INSERT) ? ST_NEED_GROW : ST_NOT_FOUND;
            out_nxt.slot   = '0;
          end else begin
            mod_start = 1'b1;
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (mod_done) begin
          k_nxt     = mod_rem;
          cnt_nxt   = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (mem_rdata == '0) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (ins_r) begin
            mem_we  = 1'b1;
            out_nxt = '{status: ST_INSERTED, slot: k_r[SLOT_W-1:0]};
          end else begin
            out_nxt = '{status: ST_NOT_FOUND, slot: '0};
          end
        end else if (mem_rdata == key_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (ins_r) begin
            out_nxt = '{status: ST_PRESENT, slot: '0};
          end else begin
            out_nxt = '{status: ST_FOUND, slot: k_r[SLOT_W-1:0]};
          end
        end else if (LIMIT_W'(cnt_r + 1'b1) == lim) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_nxt.status = ins_r ? ST_NEED_GROW : ST_NOT_FOUND;
          out_nxt.slot   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          k_nxt   = k_inc;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      clr_rep_r   <= 1'b0;
      out_valid_r <= 1'b0;
      size_cfg_r  <= SIZE_RESET;
      limit_cfg_r <= LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_rep_r   <= clr_rep_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_TABLE_SIZE:  size_cfg_r  <= cfg_wdata;
          CFG_PROBE_LIMIT: limit_cfg_r <= cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    ins_r <= ins_nxt;
    key_r <= key_nxt;
    out_r <= out_nxt;
  end

  lphs_mod #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_mod (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (mod_start),
    .dividend_i (key_w),
    .divisor_i  (sz),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  lphs_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (KEY_WIDTH)
  ) u_mem (
    .clk     (clk),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (k_rd_ext[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  `LPHS_ASSERT_IMP(a_we_in_rmw, mem_we, (state_r == S_CLEAR) || (state_r == S_CHECK))
  `LPHS_ASSERT_IMP(a_no_zero_insert, mem_we && (state_r == S_CHECK), mem_wdata != '0)
  `LPHS_ASSERT_IMP(a_mod_done_hash, mod_done, state_r == S_HASH)
  `LPHS_ASSERT_NXT(a_accept_acts, start && !busy, busy || out_valid)

endmodule

`default_nettype wire
